// ===== src/tlvp_pkg.sv =====
// shared types and constants for the tlv stream parser
// used by tlvp_core and tlv_stream_parser; no dependencies
package tlvp_pkg;

  localparam int unsigned CountWidth = 24;
  localparam logic [CountWidth-1:0] COUNT_MAX = {CountWidth{1'b1}};

  localparam int unsigned AddrWidth = 3;
  localparam logic REG_END_CODE    = 1'b0;
  localparam logic REG_MAX_RECORDS = 1'b1;

  localparam logic [7:0] END_CODE_RESET    = 8'd0;
  localparam logic [7:0] MAX_RECORDS_RESET = 8'd8;

  typedef enum logic [2:0] {
    PH_FIRST  = 3'd0,
    PH_LEN_HI = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_VALUE  = 3'd3,
    PH_NEXT   = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_TYPE   = 3'd0,
    ROLE_LEN_HI = 3'd1,
    ROLE_LEN_LO = 3'd2,
    ROLE_VALUE  = 3'd3,
    ROLE_END    = 3'd4,
    ROLE_IGNORE = 3'd5
  } role_t;

  typedef struct packed {
    phase_t                phase;
    logic [15:0]           remaining_value;
    logic [15:0]           declared_length;
    logic [7:0]            record_count;
    logic [7:0]            current_type;
    logic [CountWidth-1:0] byte_count;
    logic                  finished;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:           PH_FIRST,
    remaining_value: 16'd0,
    declared_length: 16'd0,
    record_count:    8'd0,
    current_type:    8'd0,
    byte_count:      '0,
    finished:        1'b0
  };

  typedef struct packed {
    role_t                 role;
    logic [7:0]            byte_out;
    logic [7:0]            record_type;
    logic [7:0]            record_index;
    logic [15:0]           value_length;
    logic                  record_end;
    logic                  done_res;
    logic                  success;
    logic [CountWidth-1:0] parsed_bytes;
  } result_t;

  typedef struct packed {
    logic [7:0] end_code;
    logic [7:0] max_records;
  } cfg_t;

endpackage

// ===== src/tlvp_core.sv =====
// per-byte parse step: next parser state and the tagged result for one byte
// depends on tlvp_pkg
module tlvp_core (
  input  tlvp_pkg::parse_state_t state,
  input  tlvp_pkg::cfg_t         cfg,
  input  logic [7:0]             data_byte,
  input  logic                   first,
  output tlvp_pkg::parse_state_t state_next,
  output tlvp_pkg::result_t      res
);

  tlvp_pkg::parse_state_t         cur;
  logic [tlvp_pkg::CountWidth-1:0] count_inc;
  logic [15:0]                     len_full;
  logic [15:0]                     remaining_dec;
  logic                            is_end;
  logic                            at_limit;

  assign cur           = first ? tlvp_pkg::STATE_RESET : state;
  assign count_inc     = (cur.byte_count == tlvp_pkg::COUNT_MAX) ? cur.byte_count
                         : cur.byte_count + 1'b1;
  assign len_full      = {cur.declared_length[15:8], data_byte};
  assign remaining_dec = cur.remaining_value - 16'd1;
  assign is_end        = (cur.phase == tlvp_pkg::PH_NEXT) && (data_byte == cfg.end_code);
  assign at_limit      = cur.record_count >= cfg.max_records;

  // next state
  always_comb begin
    state_next = cur;
    if (!cur.finished) begin
      case (cur.phase)
        tlvp_pkg::PH_FIRST, tlvp_pkg::PH_NEXT: begin
          if (is_end) begin
            state_next.byte_count = count_inc;
            state_next.finished   = 1'b1;
          end else if (at_limit) begin
            state_next.finished = 1'b1;
          end else begin
            state_next.byte_count      = count_inc;
            state_next.current_type    = data_byte;
            state_next.declared_length = 16'd0;
            state_next.phase           = tlvp_pkg::PH_LEN_HI;
          end
        end
        tlvp_pkg::PH_LEN_HI: begin
          state_next.byte_count      = count_inc;
          state_next.declared_length = {data_byte, 8'd0};
          state_next.phase           = tlvp_pkg::PH_LEN_LO;
        end
        tlvp_pkg::PH_LEN_LO: begin
          state_next.byte_count      = count_inc;
          state_next.declared_length = len_full;
          state_next.remaining_value = len_full;
          if (len_full == 16'd0) begin
            state_next.record_count = cur.record_count + 8'd1;
            state_next.phase        = tlvp_pkg::PH_NEXT;
          end else begin
            state_next.phase = tlvp_pkg::PH_VALUE;
          end
        end
        default: begin
          state_next.byte_count      = count_inc;
          state_next.remaining_value = remaining_dec;
          if (remaining_dec == 16'd0) begin
            state_next.record_count = cur.record_count + 8'd1;
            state_next.phase        = tlvp_pkg::PH_NEXT;
          end
        end
      endcase
    end
  end

  // result fields
  always_comb begin
    res              = '0;
    res.role         = tlvp_pkg::ROLE_IGNORE;
    res.byte_out     = data_byte;
    if (!cur.finished) begin
      case (cur.phase)
        tlvp_pkg::PH_FIRST, tlvp_pkg::PH_NEXT: begin
          if (is_end) begin
            res.role         = tlvp_pkg::ROLE_END;
            res.record_type  = data_byte;
            res.record_index = cur.record_count;
            res.done_res     = 1'b1;
            res.success      = 1'b1;
            res.parsed_bytes = count_inc;
          end else if (at_limit) begin
            res.done_res = 1'b1;
          end else begin
            res.role         = tlvp_pkg::ROLE_TYPE;
            res.record_type  = data_byte;
            res.record_index = cur.record_count;
          end
        end
        tlvp_pkg::PH_LEN_HI: begin
          res.role         = tlvp_pkg::ROLE_LEN_HI;
          res.record_type  = cur.current_type;
          res.record_index = cur.record_count;
        end
        tlvp_pkg::PH_LEN_LO: begin
          res.role         = tlvp_pkg::ROLE_LEN_LO;
          res.record_type  = cur.current_type;
          res.record_index = cur.record_count;
          res.value_length = len_full;
          res.record_end   = (len_full == 16'd0);
        end
        default: begin
          res.role         = tlvp_pkg::ROLE_VALUE;
          res.record_type  = cur.current_type;
          res.record_index = cur.record_count;
          res.value_length = cur.declared_length;
          res.record_end   = (remaining_dec == 16'd0);
        end
      endcase
    end
  end

endmodule

// ===== src/tlv_stream_parser.sv =====
// tlv stream parser top level: config registers, parser state and result register
// depends on tlvp_pkg and tlvp_core
// latency: a byte's result is valid the cycle after its transfer
// throughput: one byte per cycle; the next byte is taken while a result waits
// if that result is taken in the same cycle (single output register)
// reset: clears parser state, output valid and config to end_code 0, max_records 8
module tlv_stream_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [tlvp_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        first,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  role,
  output logic [7:0]  byte_out,
  output logic [7:0]  record_type,
  output logic [7:0]  record_index,
  output logic [15:0] value_length,
  output logic        record_end,
  output logic        done_res,
  output logic        success,
  output logic [tlvp_pkg::CountWidth-1:0] parsed_bytes
);

  tlvp_pkg::cfg_t         cfg;
  tlvp_pkg::parse_state_t state;
  tlvp_pkg::parse_state_t state_next;
  tlvp_pkg::result_t      res;
  tlvp_pkg::result_t      res_q;
  logic                   cfg_write;
  logic                   in_xfer;
  logic                   reg_sel;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.end_code    <= tlvp_pkg::END_CODE_RESET;
      cfg.max_records <= tlvp_pkg::MAX_RECORDS_RESET;
    end else if (cfg_write) begin
      case (reg_sel)
        tlvp_pkg::REG_END_CODE:    cfg.end_code    <= pwdata[7:0];
        tlvp_pkg::REG_MAX_RECORDS: cfg.max_records <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      tlvp_pkg::REG_END_CODE:    prdata = {24'd0, cfg.end_code};
      tlvp_pkg::REG_MAX_RECORDS: prdata = {24'd0, cfg.max_records};
      default:                   prdata = 32'd0;
    endcase
  end

  assign in_stall = out_valid && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  tlvp_core u_core (
    .state      (state),
    .cfg        (cfg),
    .data_byte  (data_byte),
    .first      (first),
    .state_next (state_next),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tlvp_pkg::STATE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (in_xfer) begin
        state <= state_next;
      end
      if (in_xfer) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_q <= res;
    end
  end

  assign role         = res_q.role;
  assign byte_out     = res_q.byte_out;
  assign record_type  = res_q.record_type;
  assign record_index = res_q.record_index;
  assign value_length = res_q.value_length;
  assign record_end   = res_q.record_end;
  assign done_res     = res_q.done_res;
  assign success      = res_q.success;
  assign parsed_bytes = res_q.parsed_bytes;

  a_success_is_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && success |-> done_res && (role == tlvp_pkg::ROLE_END))
    else $error("success without end code result");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty result register");

  a_record_end_role: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_end |->
      (role == tlvp_pkg::ROLE_LEN_LO) || (role == tlvp_pkg::ROLE_VALUE))
    else $error("record end on a non length or value byte");

  a_done_finishes: assert property (@(posedge clk) disable iff (rst)
    in_xfer && res.done_res |=> state.finished)
    else $error("message done but parser not finished");

endmodule

// ===== sim/tlv_stream_parser_tb.sv =====
// self-checking testbench for tlv_stream_parser: byte stream in, tagged bytes out
// depends on tlvp_pkg and the tlv_stream_parser rtl; predicts each tagged byte in place
module tlv_stream_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;
  localparam logic [tlvp_pkg::AddrWidth-1:0] ADDR_END_CODE    = {tlvp_pkg::REG_END_CODE, 2'b00};
  localparam logic [tlvp_pkg::AddrWidth-1:0] ADDR_MAX_RECORDS =
    {tlvp_pkg::REG_MAX_RECORDS, 2'b00};

  typedef struct packed {
    logic [7:0] b;
    logic       f;
  } byte_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [tlvp_pkg::AddrWidth-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        first = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  role;
  logic [7:0]  byte_out;
  logic [7:0]  record_type;
  logic [7:0]  record_index;
  logic [15:0] value_length;
  logic        record_end;
  logic        done_res;
  logic        success;
  logic [tlvp_pkg::CountWidth-1:0] parsed_bytes;

  tlv_stream_parser DUT (.*);

  // predictor copy of the registers and parser state
  logic [7:0]  cfg_end = tlvp_pkg::END_CODE_RESET;
  logic [7:0]  cfg_max = tlvp_pkg::MAX_RECORDS_RESET;
  tlvp_pkg::phase_t ph = tlvp_pkg::PH_FIRST;
  logic [15:0] left_bytes = '0;
  logic [15:0] decl_len = '0;
  logic [7:0]  rec_cnt = '0;
  logic [7:0]  cur_type = '0;
  logic [tlvp_pkg::CountWidth-1:0] consumed = '0;
  logic        msg_done = 1'b0;

  byte_item_t  byte_queue[$];
  tlvp_pkg::result_t expected_results[$];
  byte_item_t  next_item;
  tlvp_pkg::result_t want;
  int          err_count = 0;
  int          pushed = 0;
  int          cyc = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          stall_mode = 0;

  initial forever #2 clk = ~clk;

  function automatic void bump_count();
    if (consumed != tlvp_pkg::COUNT_MAX) consumed++;
  endfunction

  function automatic tlvp_pkg::result_t parse_byte(input logic [7:0] b, input logic f);
    tlvp_pkg::result_t r;
    r = '0;
    r.role = tlvp_pkg::ROLE_IGNORE;
    r.byte_out = b;
    if (f) begin
      ph = tlvp_pkg::PH_FIRST;
      left_bytes = '0;
      decl_len = '0;
      rec_cnt = '0;
      cur_type = '0;
      consumed = '0;
      msg_done = 1'b0;
    end
    if (!msg_done) begin
      case (ph)
        tlvp_pkg::PH_FIRST, tlvp_pkg::PH_NEXT: begin
          if (ph == tlvp_pkg::PH_NEXT && b == cfg_end) begin
            bump_count();
            r.role = tlvp_pkg::ROLE_END;
            r.record_type = b;
            r.record_index = rec_cnt;
            r.done_res = 1'b1;
            r.success = 1'b1;
            r.parsed_bytes = consumed;
            msg_done = 1'b1;
          end else if (rec_cnt >= cfg_max) begin
            r.done_res = 1'b1;
            msg_done = 1'b1;
          end else begin
            bump_count();
            cur_type = b;
            decl_len = '0;
            r.role = tlvp_pkg::ROLE_TYPE;
            r.record_type = b;
            r.record_index = rec_cnt;
            ph = tlvp_pkg::PH_LEN_HI;
          end
        end
        tlvp_pkg::PH_LEN_HI: begin
          bump_count();
          decl_len = {b, 8'd0};
          r.role = tlvp_pkg::ROLE_LEN_HI;
          r.record_type = cur_type;
          r.record_index = rec_cnt;
          ph = tlvp_pkg::PH_LEN_LO;
        end
        tlvp_pkg::PH_LEN_LO: begin
          bump_count();
          decl_len = decl_len | {8'd0, b};
          left_bytes = decl_len;
          r.role = tlvp_pkg::ROLE_LEN_LO;
          r.record_type = cur_type;
          r.record_index = rec_cnt;
          r.value_length = decl_len;
          if (decl_len == 16'd0) begin
            r.record_end = 1'b1;
            rec_cnt++;
            ph = tlvp_pkg::PH_NEXT;
          end else begin
            ph = tlvp_pkg::PH_VALUE;
          end
        end
        default: begin
          bump_count();
          r.role = tlvp_pkg::ROLE_VALUE;
          r.record_type = cur_type;
          r.record_index = rec_cnt;
          r.value_length = decl_len;
          left_bytes = left_bytes - 16'd1;
          if (left_bytes == 16'd0) begin
            r.record_end = 1'b1;
            rec_cnt++;
            ph = tlvp_pkg::PH_NEXT;
          end
        end
      endcase
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CycleLimit) begin
      $display("** tlv_stream_parser: FAILED **");
      $finish;
    end
  end

  // sender: bursts of transfers with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(parse_byte(data_byte, first));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (byte_queue.size() != 0) begin
          next_item = byte_queue.pop_front();
          data_byte <= next_item.b;
          first <= next_item.f;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                      : $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each transfer, stalls on its own pattern
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result, expected none, got byte %0h", $time, byte_out);
        end else begin
          want = expected_results.pop_front();
          check_field("role", int'(want.role), int'(role));
          check_field("byte_out", int'(want.byte_out), int'(byte_out));
          check_field("record_type", int'(want.record_type), int'(record_type));
          check_field("record_index", int'(want.record_index), int'(record_index));
          check_field("value_length", int'(want.value_length), int'(value_length));
          check_field("record_end", int'(want.record_end), int'(record_end));
          check_field("done_res", int'(want.done_res), int'(done_res));
          check_field("success", int'(want.success), int'(success));
          check_field("parsed_bytes", int'(want.parsed_bytes), int'(parsed_bytes));
        end
      end
      if (cyc % 50 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= cyc[1];
      endcase
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic f);
    byte_queue.push_back('{b: b, f: f});
    pushed++;
  endtask

  task automatic push_record(input logic is_first, input int len_max);
    logic [7:0]  t;
    logic [15:0] len;
    t = 8'($urandom_range(0, 255));
    if (!is_first && t == cfg_end) t = ~t;
    len = ($urandom_range(0, 39) == 0) ? 16'($urandom_range(256, 300))
                                       : 16'($urandom_range(0, len_max));
    push_byte(t, is_first);
    push_byte(len[15:8], 1'b0);
    push_byte(len[7:0], 1'b0);
    repeat (len) push_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic push_message();
    int kind;
    int lim;
    int nrec;
    logic over;
    kind = $urandom_range(0, 9);
    lim = (cfg_max < 6) ? int'(cfg_max) : 6;
    over = (kind == 7) && (cfg_max <= 6);
    if (kind == 9) begin
      repeat ($urandom_range(1, 8)) begin
        push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
    end else if (kind == 8) begin
      nrec = $urandom_range(0, lim - 1);
      for (int k = 0; k < nrec; k++) push_record(k == 0, 6);
      push_byte(8'($urandom_range(0, 255)), nrec == 0);
      repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      nrec = over ? int'(cfg_max) : $urandom_range(1, lim);
      for (int k = 0; k < nrec; k++) push_record(k == 0, (kind < 4) ? 6 : 20);
      push_byte(over ? ~cfg_end : cfg_end, 1'b0);
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    end
  endtask

  task automatic wait_drained();
    while (byte_queue.size() != 0 || in_valid || expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tlvp_pkg::AddrWidth-1:0] a, input logic [7:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= {24'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (a == ADDR_END_CODE) cfg_end = v;
    else cfg_max = v;
  endtask

  task automatic set_config(input logic [7:0] end_v, input logic [7:0] max_v);
    wait_drained();
    repeat (3) @(posedge clk);
    write_reg(ADDR_END_CODE, end_v);
    write_reg(ADDR_MAX_RECORDS, max_v);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // message before any first mark, zero length record, then end code
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    // longest declared length, cut short by a restart
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'hAB, 1'b0);
    push_byte(8'h00, 1'b0);

    // record limit of one: second type byte fails, first byte equal to end code
    set_config(8'hFF, 8'd1);
    push_byte(8'h12, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(8'h56, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);

    for (int p = 0; p < 8; p++) begin
      set_config((p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom_range(0, 255)),
                 (p == 2) ? 8'd1 : (p == 3) ? 8'd255 : 8'($urandom_range(1, 10)));
      pushed = 0;
      while (pushed < 240) push_message();
    end

    wait_drained();
    repeat (5) @(posedge clk);
    if (err_count == 0) begin
      $display("** tlv_stream_parser: PASSED **");
    end else begin
      $display("** tlv_stream_parser: FAILED **");
    end
    $finish;
  end

endmodule
